// ===== rtl/known_bits_transfer_unit_core_assert.svh =====
// Assertion macros used by the known-bits transfer unit checker.
`ifndef KNOWN_BITS_TRANSFER_UNIT_CORE_ASSERT_SVH
`define KNOWN_BITS_TRANSFER_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kbt_pkg.sv =====
// Types and opcode constants of the known-bits transfer unit.
`timescale 1ns / 1ps

package kbt_pkg;

	localparam int KIND_W   = 5;
	localparam int WFIELD_W = 7;
	localparam int MASK_W   = 64;

	localparam logic [KIND_W-1:0] KIND_AND   = 5'd0;
	localparam logic [KIND_W-1:0] KIND_OR    = 5'd1;
	localparam logic [KIND_W-1:0] KIND_XOR   = 5'd2;
	localparam logic [KIND_W-1:0] KIND_NOT   = 5'd3;
	localparam logic [KIND_W-1:0] KIND_ADD   = 5'd4;
	localparam logic [KIND_W-1:0] KIND_SUB   = 5'd5;
	localparam logic [KIND_W-1:0] KIND_TRUNC = 5'd6;
	localparam logic [KIND_W-1:0] KIND_ZEXT  = 5'd7;
	localparam logic [KIND_W-1:0] KIND_SEXT  = 5'd8;
	localparam logic [KIND_W-1:0] KIND_SHL   = 5'd9;
	localparam logic [KIND_W-1:0] KIND_SHR   = 5'd10;
	localparam logic [KIND_W-1:0] KIND_SAR   = 5'd11;
	localparam logic [KIND_W-1:0] KIND_EQ    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_NE    = 5'd13;
	localparam logic [KIND_W-1:0] KIND_SLT   = 5'd14;
	localparam logic [KIND_W-1:0] KIND_SLE   = 5'd15;
	localparam logic [KIND_W-1:0] KIND_SGT   = 5'd16;
	localparam logic [KIND_W-1:0] KIND_SGE   = 5'd17;
	localparam logic [KIND_W-1:0] KIND_ULT   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_ULE   = 5'd19;
	localparam logic [KIND_W-1:0] KIND_UGT   = 5'd20;
	localparam logic [KIND_W-1:0] KIND_UGE   = 5'd21;
	localparam logic [KIND_W-1:0] KIND_MEET  = 5'd22;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [WFIELD_W-1:0] result_width;
		logic [WFIELD_W-1:0] src_width;
		logic [WFIELD_W-1:0] amt_width;
		logic [MASK_W-1:0]   left_zero;
		logic [MASK_W-1:0]   left_one;
		logic [MASK_W-1:0]   right_zero;
		logic [MASK_W-1:0]   right_one;
		logic                same_operand;
	} kbt_req_t;

	typedef struct packed {
		logic [MASK_W-1:0] known_zero;
		logic [MASK_W-1:0] known_one;
		logic              fully_known;
	} kbt_rsp_t;

	// Outcome of a compare: decided, and if so the boolean value.
	typedef struct packed {
		logic decided;
		logic value;
	} kbt_verdict_t;

endpackage

// ===== rtl/kbt_addsub.sv =====
// Known-bits add/subtract from the minimum and maximum carry chains.
`timescale 1ns / 1ps

module kbt_addsub #(
	parameter int DATA_WIDTH = 64
) (
	input  logic [DATA_WIDTH-1:0] az,
	input  logic [DATA_WIDTH-1:0] ao,
	input  logic [DATA_WIDTH-1:0] bz,
	input  logic [DATA_WIDTH-1:0] bo,
	input  logic                  sub,
	output logic [DATA_WIDTH-1:0] rz,
	output logic [DATA_WIDTH-1:0] ro
);

	logic [DATA_WIDTH-1:0] bz_x, bo_x, ao_n, bo_n;
	logic [DATA_WIDTH-1:0] cin;
	logic [DATA_WIDTH-1:0] max_sum, min_sum, carry_max, carry_min, known;

	always_comb begin
		// subtract: swap b's masks, carry in of one
		bz_x = sub ? bo : bz;
		bo_x = sub ? bz : bo;
		// a bit marked both ways counts as zero
		ao_n = ao & ~az;
		bo_n = bo_x & ~bz_x;
		cin  = DATA_WIDTH'(sub);

		max_sum = ~az + ~bz_x + cin;
		min_sum = ao_n + bo_n + cin;
		carry_max = max_sum ^ ~az ^ ~bz_x;
		carry_min = min_sum ^ ao_n ^ bo_n;

		known = (az | ao_n) & (bz_x | bo_n) & ~(carry_max ^ carry_min);
		rz = ~min_sum & known;
		ro = min_sum & known;
	end

endmodule

// ===== rtl/kbt_shift.sv =====
// Known-bits shifts by a fully known amount.
`timescale 1ns / 1ps

module kbt_shift #(
	parameter int DATA_WIDTH = 64
) (
	input  logic [kbt_pkg::KIND_W-1:0]      kind,
	input  logic [DATA_WIDTH-1:0]           az,
	input  logic [DATA_WIDTH-1:0]           ao,
	input  logic [DATA_WIDTH-1:0]           bz,
	input  logic [DATA_WIDTH-1:0]           bo,
	input  logic [DATA_WIDTH-1:0]           shm,
	input  logic [DATA_WIDTH-1:0]           m,
	input  logic [$clog2(DATA_WIDTH+1)-1:0] w,
	output logic [DATA_WIDTH-1:0]           rz,
	output logic [DATA_WIDTH-1:0]           ro
);
	import kbt_pkg::*;

	localparam int WW = $clog2(DATA_WIDTH + 1);
	localparam int IW = $clog2(DATA_WIDTH);

	logic                  amt_ok;
	logic [IW-1:0]         sh;
	logic [WW-1:0]         w_left;
	logic [DATA_WIDTH-1:0] low_sh, upper, top;

	always_comb begin
		amt_ok = (((bz | bo) & shm) == shm) && (bo < DATA_WIDTH'(w));
		sh     = bo[IW-1:0];
		w_left = w - WW'(sh);
		low_sh = ~({DATA_WIDTH{1'b1}} << sh);
		upper  = m & ({DATA_WIDTH{1'b1}} << w_left);
		top    = m & ~(m >> 1);

		rz = '0;
		ro = '0;
		if (amt_ok) begin
			if (kind == KIND_SHL) begin
				rz = (az << sh) | low_sh;
				ro = ao << sh;
			end else begin
				rz = az >> sh;
				ro = ao >> sh;
				if (kind == KIND_SHR || (|(az & top))) begin
					rz = rz | upper;
				end else if (|(ao & top)) begin
					ro = ro | upper;
				end
			end
		end
	end

endmodule

// ===== rtl/kbt_cmp.sv =====
// Known-bits compares decided from operand bounds.
`timescale 1ns / 1ps

module kbt_cmp #(
	parameter int DATA_WIDTH = 64
) (
	input  logic [kbt_pkg::KIND_W-1:0] kind,
	input  logic [DATA_WIDTH-1:0]      az,
	input  logic [DATA_WIDTH-1:0]      ao,
	input  logic [DATA_WIDTH-1:0]      bz,
	input  logic [DATA_WIDTH-1:0]      bo,
	input  logic [DATA_WIDTH-1:0]      sm,
	input  logic                       same,
	output kbt_pkg::kbt_verdict_t      verdict
);
	import kbt_pkg::*;

	logic                  signed_op, conflict, exact;
	logic [DATA_WIDTH-1:0] top, faz, fao, fbz, fbo;
	logic [DATA_WIDTH-1:0] amin, amax, bmin, bmax;
	logic                  amax_lt_bmin, bmax_lt_amin, amax_le_bmin, bmax_le_amin;
	logic                  t, f;

	always_comb begin
		signed_op = (kind == KIND_SLT) || (kind == KIND_SLE) ||
			(kind == KIND_SGT) || (kind == KIND_SGE);
		// signed order maps to unsigned order with the sign bit inverted
		top = signed_op ? (sm & ~(sm >> 1)) : '0;
		faz = (az & ~top) | (ao & top);
		fao = (ao & ~top) | (az & top);
		fbz = (bz & ~top) | (bo & top);
		fbo = (bo & ~top) | (bz & top);

		amin = fao;
		amax = ~faz & sm;
		bmin = fbo;
		bmax = ~fbz & sm;

		amax_lt_bmin = amax < bmin;
		bmax_lt_amin = bmax < amin;
		amax_le_bmin = amax <= bmin;
		bmax_le_amin = bmax <= amin;

		conflict = (|(fao & fbz)) || (|(faz & fbo));
		exact    = same || ((amin == amax) && (bmin == bmax));

		t = 1'b0;
		f = 1'b0;
		unique case (kind) inside
			KIND_EQ, KIND_NE: begin
				if (conflict) begin
					f = 1'b1;
				end else if (exact) begin
					t = (amin == bmin);
					f = (amin != bmin);
				end
				if (kind == KIND_NE) begin
					{t, f} = {f, t};
				end
			end
			KIND_SLT, KIND_ULT: begin
				t = amax_lt_bmin;
				f = same || bmax_le_amin;
			end
			KIND_SLE, KIND_ULE: begin
				t = same || amax_le_bmin;
				f = bmax_lt_amin;
			end
			KIND_SGT, KIND_UGT: begin
				t = bmax_lt_amin;
				f = same || amax_le_bmin;
			end
			KIND_SGE, KIND_UGE: begin
				t = same || bmax_le_amin;
				f = amax_lt_bmin;
			end
			default: begin
				t = 1'b0;
				f = 1'b0;
			end
		endcase

		// a proven-true outcome wins over a proven-false one
		verdict.decided = t || f;
		verdict.value   = t;
	end

endmodule

// ===== rtl/kbt_xfer.sv =====
// Transfer logic: masks operands and selects the result for one opcode.
`timescale 1ns / 1ps

module kbt_xfer #(
	parameter int DATA_WIDTH = 64
) (
	input  logic [kbt_pkg::KIND_W-1:0]      kind,
	input  logic [$clog2(DATA_WIDTH+1)-1:0] w,
	input  logic [$clog2(DATA_WIDTH+1)-1:0] srcw,
	input  logic [$clog2(DATA_WIDTH+1)-1:0] shw,
	input  logic [DATA_WIDTH-1:0]           lz,
	input  logic [DATA_WIDTH-1:0]           lo,
	input  logic [DATA_WIDTH-1:0]           rz_in,
	input  logic [DATA_WIDTH-1:0]           ro_in,
	input  logic                            same,
	output logic [DATA_WIDTH-1:0]           rz,
	output logic [DATA_WIDTH-1:0]           ro,
	output logic                            full
);
	import kbt_pkg::*;

	logic [DATA_WIDTH-1:0] m, sm, shm, upper, sign;
	logic [DATA_WIDTH-1:0] a_z, a_o, b_z, b_o, as_z, as_o, bs_z, bs_o, bsh_z, bsh_o;
	logic [DATA_WIDTH-1:0] add_z, add_o, sh_z, sh_o, r_z, r_o;
	kbt_verdict_t          verdict;

	always_comb begin
		m   = ~({DATA_WIDTH{1'b1}} << w);
		sm  = ~({DATA_WIDTH{1'b1}} << srcw);
		shm = ~({DATA_WIDTH{1'b1}} << shw);

		a_z   = lz & m;
		a_o   = lo & m;
		b_z   = rz_in & m;
		b_o   = ro_in & m;
		as_z  = lz & sm;
		as_o  = lo & sm;
		bs_z  = rz_in & sm;
		bs_o  = ro_in & sm;
		bsh_z = rz_in & shm;
		bsh_o = ro_in & shm;

		upper = m & ~sm;
		sign  = sm & ~(sm >> 1);
	end

	kbt_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_addsub (
		.az  (a_z),
		.ao  (a_o),
		.bz  (b_z),
		.bo  (b_o),
		.sub (kind == KIND_SUB),
		.rz  (add_z),
		.ro  (add_o)
	);

	kbt_shift #(.DATA_WIDTH(DATA_WIDTH)) u_shift (
		.kind (kind),
		.az   (a_z),
		.ao   (a_o),
		.bz   (bsh_z),
		.bo   (bsh_o),
		.shm  (shm),
		.m    (m),
		.w    (w),
		.rz   (sh_z),
		.ro   (sh_o)
	);

	kbt_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
		.kind    (kind),
		.az      (as_z),
		.ao      (as_o),
		.bz      (bs_z),
		.bo      (bs_o),
		.sm      (sm),
		.same    (same),
		.verdict (verdict)
	);

	always_comb begin
		r_z = '0;
		r_o = '0;
		unique case (kind) inside
			KIND_AND: begin
				r_z = a_z | b_z;
				r_o = a_o & b_o;
			end
			KIND_OR: begin
				r_z = a_z & b_z;
				r_o = a_o | b_o;
			end
			KIND_XOR: begin
				r_z = (a_z & b_z) | (a_o & b_o);
				r_o = (a_z & b_o) | (a_o & b_z);
			end
			KIND_NOT: begin
				r_z = a_o;
				r_o = a_z;
			end
			KIND_ADD, KIND_SUB: begin
				r_z = add_z;
				r_o = add_o;
			end
			KIND_TRUNC: begin
				r_z = as_z;
				r_o = as_o;
			end
			KIND_ZEXT, KIND_SEXT: begin
				r_z = as_z;
				r_o = as_o;
				if (kind == KIND_ZEXT || (|(as_z & sign))) begin
					r_z = as_z | upper;
				end else if (|(as_o & sign)) begin
					r_o = as_o | upper;
				end
			end
			KIND_SHL, KIND_SHR, KIND_SAR: begin
				r_z = sh_z;
				r_o = sh_o;
			end
			[KIND_EQ:KIND_UGE]: begin
				// verdict lands in bit 0
				r_z = DATA_WIDTH'(verdict.decided && !verdict.value);
				r_o = DATA_WIDTH'(verdict.decided && verdict.value);
			end
			KIND_MEET: begin
				r_z = a_z & b_z;
				r_o = a_o & b_o;
			end
			default: begin
				r_z = '0;
				r_o = '0;
			end
		endcase

		rz   = r_z & m;
		ro   = r_o & m;
		full = ((rz | ro) == m);
	end

endmodule

// ===== rtl/known_bits_transfer_unit_core.sv =====
// Top level of the known-bits transfer unit: input and result registers.
`timescale 1ns / 1ps

// Known-bits transfer unit. Each req item carries an opcode, widths and the
// known-zero / known-one masks of two operands; each rsp item carries the
// result masks and a fully_known flag. One rsp item per req item, in order.
// Both channels use valid/stall: an item moves on a clock edge where valid
// is high and stall is low.
// An accepted req item passes the input register, then the result register
// fed by the combinational transfer logic, and then leaves as the rsp item.
// Throughput: one item per cycle while rsp_stall is low; the carry chains of the
// add/subtract unit and the bound compares set the path between the two registers.
// When rsp_stall holds, the result register keeps its item and the input
// register can still take one more item; req_stall rises only when both
// registers are full and the receiver is stalling.
// Reset (arst_n low) empties both registers; items held in them are dropped and no item is produced.
// DATA_WIDTH sets the widest operand; widths above it are read as
// DATA_WIDTH, a width of zero as one. Mask bits above DATA_WIDTH read zero.
module known_bits_transfer_unit_core #(
	parameter int DATA_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  kbt_pkg::kbt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output kbt_pkg::kbt_rsp_t rsp
);
	import kbt_pkg::*;

	localparam int WW = $clog2(DATA_WIDTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [WW-1:0]         w;
		logic [WW-1:0]         srcw;
		logic [WW-1:0]         shw;
		logic [DATA_WIDTH-1:0] lz;
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] rz;
		logic [DATA_WIDTH-1:0] ro;
		logic                  same;
	} op_t;

	function automatic logic [WW-1:0] clamp_w(input logic [WFIELD_W-1:0] wf);
		logic [WW-1:0] res;
		if (wf == '0) begin
			res = WW'(1);
		end else if (wf > WFIELD_W'(DATA_WIDTH)) begin
			res = WW'(DATA_WIDTH);
		end else begin
			res = WW'(wf);
		end
		return res;
	endfunction

	logic                  valid_s1, valid_s2;
	op_t                   op_s1;
	logic [DATA_WIDTH-1:0] rz_s2, ro_s2;
	logic                  full_s2;
	logic                  load_s1, load_s2;
	logic [DATA_WIDTH-1:0] x_rz, x_ro;
	logic                  x_full;

	assign load_s2   = !valid_s2 || !rsp_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign req_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= req_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			op_s1.kind <= req.kind;
			op_s1.w    <= clamp_w(req.result_width);
			op_s1.srcw <= clamp_w(req.src_width);
			op_s1.shw  <= clamp_w(req.amt_width);
			op_s1.lz   <= req.left_zero[DATA_WIDTH-1:0];
			op_s1.lo   <= req.left_one[DATA_WIDTH-1:0];
			op_s1.rz   <= req.right_zero[DATA_WIDTH-1:0];
			op_s1.ro   <= req.right_one[DATA_WIDTH-1:0];
			op_s1.same <= req.same_operand;
		end
		if (load_s2 && valid_s1) begin
			rz_s2   <= x_rz;
			ro_s2   <= x_ro;
			full_s2 <= x_full;
		end
	end

	kbt_xfer #(.DATA_WIDTH(DATA_WIDTH)) u_xfer (
		.kind  (op_s1.kind),
		.w     (op_s1.w),
		.srcw  (op_s1.srcw),
		.shw   (op_s1.shw),
		.lz    (op_s1.lz),
		.lo    (op_s1.lo),
		.rz_in (op_s1.rz),
		.ro_in (op_s1.ro),
		.same  (op_s1.same),
		.rz    (x_rz),
		.ro    (x_ro),
		.full  (x_full)
	);

	assign rsp_valid       = valid_s2;
	assign rsp.known_zero  = MASK_W'(rz_s2);
	assign rsp.known_one   = MASK_W'(ro_s2);
	assign rsp.fully_known = full_s2;

endmodule

// ===== rtl/kbt_checker.sv =====
// Port-level checks of the known-bits transfer unit, bound to the top level.
`timescale 1ns / 1ps
`include "known_bits_transfer_unit_core_assert.svh"

module kbt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input kbt_pkg::kbt_rsp_t rsp
);

	logic req_take, rsp_held, quiet;

	assign req_take = req_valid && !req_stall;
	assign rsp_held = rsp_valid && rsp_stall;
	assign quiet    = !req_take && !rsp_held;

	// a held result stays put
	`KBT_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid && $stable(rsp), "held rsp changed")

	// back-pressure on req only comes from a stalled rsp
	`KBT_ASSERT_IMP(a_stall_cause, clk, arst_n, req_stall, rsp_held, "req stall with no rsp stall")

	// an accepted item passes both registers to rsp_valid unless rsp is held
	`KBT_ASSERT_NXT(a_latency, clk, arst_n, req_take ##1 !rsp_held, rsp_valid, "item late")

	// with no items coming in and nothing held, the output drains
	`KBT_ASSERT_NXT(a_no_ghost, clk, arst_n, quiet ##1 quiet, !rsp_valid, "rsp item without req item")

endmodule

bind known_bits_transfer_unit_core kbt_checker u_kbt_checker (.*);
